// ===== rtl/core/lgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation stencil core.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 1024;
    localparam int LINE_ADDR_W  = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 9;
    localparam int HEIGHT_W     = 11;
    localparam int COUNT_W      = 19;
    localparam int CFG_DATA_W   = 11;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic req_type;
        logic cell_alive;
    } in_item_t;

    typedef struct packed {
        logic               next_alive;
        logic               last_of_frame;
        logic [COUNT_W-1:0] live_count;
    } out_item_t;

    // edge and emit flags that travel with a cell down the pipeline
    typedef struct packed {
        logic emit;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } win_flags_t;

endpackage : lgs_pkg
`default_nettype wire

// ===== rtl/core/life_generation_stencil_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_stencil_core
// One B3/S23 generation over a raster cell stream, using a two-row line
// store RAM and a 3x3 sliding window.
// Throughput: one item per cycle while the output is not stalled; the line
//   store RAM is read and written once per item, with forwarding when
//   consecutive items share an address. The item completing a cell's window
//   (W+1 items after it) passes stage 1, stage 2 and the output register.
// Reset: position, window, live count and pipeline valids clear; the line
//   store is not cleared (rows outside the grid are masked).
// ----------------------------------------------------------------------------
module life_generation_stencil_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire lgs_pkg::cfg_reg_t               cfg_index,
    input  wire logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire lgs_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lgs_pkg::out_item_t                   out_data
);
    import lgs_pkg::*;

    localparam logic [8:0] MASK_TOP    = 9'h049;
    localparam logic [8:0] MASK_BOTTOM = 9'h124;
    localparam logic [8:0] MASK_LEFT   = 9'h007;
    localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
    localparam logic [8:0] BIT_CENTRE  = 9'h010;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [WIDTH_W-1:0]  W_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] H_MAX  = HEIGHT_W'(MAX_HEIGHT);

    // configuration
    logic [WIDTH_W-1:0]  w_reg;
    logic [HEIGHT_W-1:0] h_reg;
    logic [WIDTH_W-1:0]  w_cfg;
    logic [HEIGHT_W-1:0] h_cfg;

    // position of the next arriving item
    logic [LINE_ADDR_W-1:0] col_reg, col_next;
    logic [HEIGHT_W-1:0]    row_reg, row_next;

    // stage 1: line store read in flight
    logic                   s1_valid_reg;
    win_flags_t             s1_flags_reg;
    logic                   s1_v_reg;
    logic [LINE_ADDR_W-1:0] s1_addr_reg;
    logic                   s1_fwd_reg;
    logic [1:0]             s1_fwd_data_reg;

    // stage 2: window evaluation
    logic                   s2_valid_reg;
    win_flags_t             s2_flags_reg;
    logic [8:0]             window_reg, window_next;
    logic [COUNT_W-1:0]     alive_total_reg;

    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    // handshake
    logic accept, out_ready, s2_free, s1_adv, s2_adv;

    // stage A
    logic [WIDTH_W:0]        a_c;
    logic [HEIGHT_W:0]       a_r;
    logic [WIDTH_W:0]        a_c1;
    logic [HEIGHT_W:0]       a_r1;
    logic [HEIGHT_W:0]       a_crow;
    logic [WIDTH_W:0]        a_ccol;
    logic                    a_v;
    win_flags_t              a_flags;
    logic                    a_hit;

    // stage 1 comb
    logic [1:0] ram_rd_data, line_eff, ram_wr_data;
    logic [2:0] s1_col;

    // stage 2 comb
    logic [8:0]         win_masked;
    logic [3:0]         nbr_count;
    logic               s2_alive;
    logic [COUNT_W-1:0] count_new;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data[WIDTH_W-1:0] < WIDTH_W'(3))
            w_cfg = WIDTH_W'(3);
        else if (cfg_data[WIDTH_W-1:0] > W_MAX)
            w_cfg = W_MAX;
        else
            w_cfg = cfg_data[WIDTH_W-1:0];

        if (cfg_data[HEIGHT_W-1:0] < HEIGHT_W'(3))
            h_cfg = HEIGHT_W'(3);
        else if (cfg_data[HEIGHT_W-1:0] > H_MAX)
            h_cfg = H_MAX;
        else
            h_cfg = cfg_data[HEIGHT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WIDTH_W'(200);
            h_reg <= HEIGHT_W'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  w_reg <= w_cfg;
                REG_GRID_HEIGHT: h_reg <= h_cfg;
                default: ;
            endcase
        end
    end

    // handshake and pipeline advance
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_free   = !s2_valid_reg || !s2_flags_reg.emit || out_ready;
    assign s2_adv    = s2_valid_reg && s2_free;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign accept    = in_valid && !in_stall;

    // stage A: position, emit decision and edge flags
    always_comb
    begin
        a_c  = {2'b00, col_reg};
        a_r  = {1'b0, row_reg};
        if (a_c >= {1'b0, w_reg})
        begin
            a_c = '0;
            a_r = a_r + 1'b1;
        end
        if (a_r > {1'b0, h_reg} + 1'b1)
        begin
            a_r = {1'b0, h_reg} + 1'b1;
            a_c = '0;
        end

        a_v = (a_r < {1'b0, h_reg}) && !in_data.req_type && in_data.cell_alive;

        if (a_c != '0)
        begin
            a_flags.emit = (a_r >= 1) && ((a_r - 1'b1) < {1'b0, h_reg});
            a_crow       = a_r - 1'b1;
            a_ccol       = a_c - 1'b1;
        end
        else
        begin
            a_flags.emit = (a_r >= 2) && ((a_r - 2'd2) < {1'b0, h_reg});
            a_crow       = a_r - 2'd2;
            a_ccol       = {1'b0, w_reg} - 1'b1;
        end
        a_flags.top    = (a_crow == '0);
        a_flags.bottom = (a_crow == {1'b0, h_reg} - 1'b1);
        a_flags.left   = (a_ccol == '0);
        a_flags.right  = (a_ccol == {1'b0, w_reg} - 1'b1);
        a_flags.last   = a_flags.emit && a_flags.bottom && a_flags.right;

        a_c1 = a_c + 1'b1;
        a_r1 = a_r;
        if (a_c1 >= {1'b0, w_reg})
        begin
            a_c1 = '0;
            a_r1 = a_r + 1'b1;
        end
        if (a_flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            col_next = a_c1[LINE_ADDR_W-1:0];
            row_next = a_r1[HEIGHT_W-1:0];
        end

        // previous item writes the same entry on this edge
        a_hit = s1_valid_reg && (s1_addr_reg == a_c[LINE_ADDR_W-1:0]);
    end

    // line store: bit 0 = row r-2, bit 1 = row r-1
    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (a_c[LINE_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign line_eff    = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign ram_wr_data = {s1_v_reg, line_eff[1]};
    assign s1_col      = {s1_v_reg, line_eff[1], line_eff[0]};
    assign window_next = {s1_col, window_reg[8:3]};

    // stage 2: rule evaluation
    always_comb
    begin
        win_masked = window_reg;
        if (s2_flags_reg.top)    win_masked = win_masked & ~MASK_TOP;
        if (s2_flags_reg.bottom) win_masked = win_masked & ~MASK_BOTTOM;
        if (s2_flags_reg.left)   win_masked = win_masked & ~MASK_LEFT;
        if (s2_flags_reg.right)  win_masked = win_masked & ~MASK_RIGHT;

        nbr_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                nbr_count = nbr_count + {3'b000, win_masked[i]};
        end
        s2_alive = (nbr_count == 4'd3) ||
                   (((win_masked & BIT_CENTRE) != '0) && (nbr_count == 4'd2));

        count_new = alive_total_reg;
        if (s2_alive && (alive_total_reg != COUNT_MAX))
            count_new = alive_total_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s1_fwd_reg      <= 1'b0;
            s2_valid_reg    <= 1'b0;
            window_reg      <= '0;
            alive_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg         <= col_next;
                row_reg         <= row_next;
                s1_valid_reg    <= 1'b1;
                s1_fwd_reg      <= a_hit;
            end
            else if (s1_adv)
            begin
                s1_valid_reg    <= 1'b0;
            end

            if (s1_adv)
            begin
                window_reg   <= window_next;
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv && s2_flags_reg.emit)
            begin
                alive_total_reg <= s2_flags_reg.last ? '0 : count_new;
            end

            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg && s2_flags_reg.emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg    <= a_flags;
            s1_v_reg        <= a_v;
            s1_addr_reg     <= a_c[LINE_ADDR_W-1:0];
            s1_fwd_data_reg <= ram_wr_data;
        end
        if (s1_adv)
        begin
            s2_flags_reg <= s1_flags_reg;
        end
        if (s2_adv && s2_flags_reg.emit)
        begin
            out_data_reg.next_alive    <= s2_alive;
            out_data_reg.last_of_frame <= s2_flags_reg.last;
            out_data_reg.live_count    <= count_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty pipeline");

    a_fwd_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (s1_addr_reg == $past(s1_addr_reg)))
        else $error("forwarded line data for a different address");

    a_frame_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s2_flags_reg.emit && s2_flags_reg.last) |=> (alive_total_reg == '0))
        else $error("live count not cleared at end of frame");

endmodule : life_generation_stencil_core
`default_nettype wire

// ===== rtl/core/lgs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : lgs_ram
`default_nettype wire

// ===== sim/life_generation_stencil_core_tb.sv =====
// ----------------------------------------------------------------------------
// life_generation_stencil_core_tb
// Self-checking bench for the B3/S23 generation stencil. A bit-accurate
// predictor of the line stores, 3x3 window and frame position runs beside
// the core. Every cell transfer is predicted, and every result transfer is
// checked field by field against the oldest prediction. The bench covers
// directed edge patterns, the widest and tallest grids, clamped register
// values, grid changes in the middle of a frame, and random frames mixed with
// stray flushes, under three mixes of source gaps and sink backpressure.
// ----------------------------------------------------------------------------
module life_generation_stencil_core_tb;

    import lgs_pkg::*;

    localparam logic       REQ_CELL      = 1'b0;
    localparam logic       REQ_FLUSH     = 1'b1;
    localparam logic [8:0] TOP_ROW       = 9'b001_001_001;
    localparam logic [8:0] BOTTOM_ROW    = 9'b100_100_100;
    localparam logic [8:0] LEFT_COL      = 9'b000_000_111;
    localparam logic [8:0] RIGHT_COL     = 9'b111_000_000;
    localparam logic [8:0] CENTER_CELL   = 9'b000_010_000;
    localparam int         PIPE_SETTLE   = 8;
    localparam int         ROUND_CELLS   = 60;
    localparam int         TIMEOUT_LIMIT = 4_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    // predictor state
    logic [WIDTH_W-1:0]    width_reg  = 9'd200;
    logic [HEIGHT_W-1:0]   height_reg = 11'd50;
    logic                  upper_row  [MAX_WIDTH];
    logic                  middle_row [MAX_WIDTH];
    logic [8:0]            window     = '0;
    int unsigned           col_pos    = 0;
    int unsigned           row_pos    = 0;
    logic [COUNT_W-1:0]    live_total = '0;
    out_item_t             next_gen_q [$];

    int unsigned           send_gap_pct   = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           cells_sent     = 0;
    int unsigned           results_seen   = 0;
    int unsigned           frames_closed  = 0;
    int unsigned           fail_count     = 0;

    life_generation_stencil_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advance the stencil by one arriving item; returns 1 when a cell is emitted
    function automatic bit step_generation(in_item_t item, output out_item_t res);
        int unsigned w, h, r, c, crow, ccol, n;
        logic        v;
        logic [2:0]  column;
        logic [8:0]  win;
        bit          emit;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r > h + 1)
        begin
            r = h + 1;
            c = 0;
        end
        v = (r < h && item.req_type == REQ_CELL) ? item.cell_alive : 1'b0;
        column        = {v, middle_row[c], upper_row[c]};
        upper_row[c]  = middle_row[c];
        middle_row[c] = v;
        window        = {column, window[8:3]};
        if (c >= 1)
        begin
            emit = (r >= 1) && (r - 1 < h);
            crow = r - 1;
            ccol = c - 1;
        end
        else
        begin
            emit = (r >= 2) && (r - 2 < h);
            crow = r - 2;
            ccol = w - 1;
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        res     = '0;
        if (!emit)
            return 0;
        win = window;
        if (crow == 0)
            win &= ~TOP_ROW;
        if (crow == h - 1)
            win &= ~BOTTOM_ROW;
        if (ccol == 0)
            win &= ~LEFT_COL;
        if (ccol == w - 1)
            win &= ~RIGHT_COL;
        n = $countones(win & ~CENTER_CELL);
        res.next_alive = (n == 3) || ((win & CENTER_CELL) != '0 && n == 2);
        if (res.next_alive && live_total != '1)
            live_total++;
        res.live_count    = live_total;
        res.last_of_frame = (crow == h - 1) && (ccol == w - 1);
        if (res.last_of_frame)
        begin
            row_pos    = 0;
            col_pos    = 0;
            live_total = '0;
        end
        return 1;
    endfunction

    task automatic push_cell(logic req, logic alive);
        in_item_t  item;
        out_item_t res;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.req_type   = req;
        item.cell_alive = alive;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (step_generation(item, res))
            next_gen_q.push_back(res);
        cells_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (next_gen_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_GRID_WIDTH)
            width_reg = value[WIDTH_W-1:0];
        else
            height_reg = value[HEIGHT_W-1:0];
    endtask

    task automatic set_grid(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw);
        write_reg(REG_GRID_WIDTH, w_raw);
        write_reg(REG_GRID_HEIGHT, h_raw);
        cfg_valid <= 1'b0;
    endtask

    // drain whatever frame is open so the next cell starts a new generation
    task automatic finish_frame();
        while (row_pos != 0 || col_pos != 0)
            push_cell(REQ_FLUSH, 1'($urandom_range(1)));
    endtask

    task automatic send_frame(int unsigned density);
        int unsigned w, h;
        finish_frame();
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        repeat (w * h)
            push_cell(REQ_CELL, $urandom_range(99) < density);
        repeat (w + 1)
            push_cell(REQ_FLUSH, 1'($urandom_range(1)));
    endtask

    // also fills both line stores at every column before anything else runs
    task automatic test_widest_grid();
        wait_idle();
        set_grid(11'h7FF, 11'd0);
        repeat (2 * MAX_WIDTH + 1)
            push_cell(REQ_CELL, 1'($urandom_range(1)));
        wait_idle();
        // narrowing the row mid-frame wraps the rest onto a 3x3 grid
        set_grid(11'd3, 11'd0);
        finish_frame();
    endtask

    task automatic test_small_grid();
        logic [8:0] blinker;
        blinker = 9'b000_111_000;
        wait_idle();
        set_grid(11'd3, 11'd3);
        repeat (9)
            push_cell(REQ_CELL, 1'b1);
        repeat (4)
            push_cell(REQ_FLUSH, 1'b1);
        // flush inside the frame kills one blinker cell; real cells drain it
        for (int i = 0; i < 9; i++)
        begin
            if (i == 3)
                push_cell(REQ_FLUSH, 1'b1);
            else
                push_cell(REQ_CELL, blinker[i]);
        end
        repeat (4)
            push_cell(REQ_CELL, 1'b1);
    endtask

    task automatic test_tallest_grid();
        wait_idle();
        set_grid(11'd0, 11'h7FF);
        repeat (90)
            push_cell(REQ_CELL, 1'($urandom_range(1)));
        wait_idle();
        // shrinking the height below the current row closes the frame
        set_grid(11'd0, 11'd1);
        finish_frame();
    endtask

    task automatic run_random_round(int unsigned quota);
        int unsigned start;
        start = cells_sent;
        while (cells_sent - start < quota)
        begin
            if ($urandom_range(3) == 0)
            begin
                wait_idle();
                case ($urandom_range(19))
                    0:       set_grid(CFG_DATA_W'($urandom_range(3) * 512 +
                                                  $urandom_range(3, 9)),
                                      CFG_DATA_W'($urandom_range(3, 5)));
                    1:       set_grid(11'd10, 11'd3);
                    2:       set_grid(CFG_DATA_W'($urandom_range(2)),
                                      CFG_DATA_W'($urandom_range(2)));
                    default: set_grid(CFG_DATA_W'($urandom_range(3, 9)),
                                      CFG_DATA_W'($urandom_range(3, 7)));
                endcase
            end
            if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    push_cell(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else
            begin
                send_frame($urandom_range(5, 85));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_round(ROUND_CELLS);
        send_gap_pct   = 57;
        recv_stall_pct = 14;
        run_random_round(ROUND_CELLS);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random_round(ROUND_CELLS);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (out_data.last_of_frame === 1'b1)
                frames_closed++;
            if (next_gen_q.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_data);
                fail_count++;
            end
            else
            begin
                want = next_gen_q.pop_front();
                if (out_data.next_alive !== want.next_alive)
                begin
                    $error("next_alive: expected %0d, got %0d",
                           want.next_alive, out_data.next_alive);
                    fail_count++;
                end
                if (out_data.last_of_frame !== want.last_of_frame)
                begin
                    $error("last_of_frame: expected %0d, got %0d",
                           want.last_of_frame, out_data.last_of_frame);
                    fail_count++;
                end
                if (out_data.live_count !== want.live_count)
                begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, out_data.live_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_row[i]  = 1'b0;
            middle_row[i] = 1'b0;
        end
        send_gap_pct   = 14;
        recv_stall_pct = 57;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        test_widest_grid();
        test_small_grid();
        test_tallest_grid();
        test_random_traffic();
        wait_idle();
        if (next_gen_q.size() != 0)
            fail_count++;
        $display("Run covered %0d cell transfers and %0d checked results over %0d closed",
                 cells_sent, results_seen, frames_closed);
        $display("generations on grids from 3x3 to 256x1024, with mid-frame resizing.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
